// File: sv/krt_pkg.sv
// Shared types and constants for the key repeat timer table.
package krt_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CHAR_W = 21;
    localparam int unsigned IVL_W  = 16;
    localparam int unsigned KEY_W  = 8;

    localparam logic [15:0] DELAY_RESET = 16'd500;
    localparam logic [15:0] RATE_RESET  = 16'd33;

    // operation codes (tuser)
    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_SET_CHAR = 1'b1;

    // register select, paddr[2]
    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_RATE  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] last_fire_stamp;
        logic              repeating;
        logic [CHAR_W-1:0] character;
    } key_entry_t;

    typedef struct packed {
        logic              operation;
        logic [KEY_W-1:0]  key_index;
        logic              down_now;
        logic              press_edge;
        logic [TIME_W-1:0] now_ms;
        logic [CHAR_W-1:0] new_character;
        logic              frame_start;
    } sample_t;

    typedef struct packed {
        logic              key_fired;
        logic [CHAR_W-1:0] fired_character;
        logic [CHAR_W-1:0] frame_text;
    } result_t;

endpackage

// File: sv/key_repeat_timer_table.sv
// Top level: per-key typematic repeat timer with a key entry memory.
//
//  channel   | dir | handshake                | payload
//  ----------+-----+--------------------------+--------------------------------
//  s_*       | in  | s_tvalid / s_tready      | key sample or set-character beat
//  m_*       | out | m_tvalid / m_tready      | fire flag, character, frame text
//  apb       | in  | psel & penable & pwrite  | repeat_delay_ms, repeat_rate_ms
//
// One beat per cycle while the output is not stalled; a taken beat's entry is
// read from the entry memory at the accepting edge, and its update then goes
// into the result register.
// After reset the entry memory is cleared, one key per cycle, across all NUM_KEYS
// entries; s_tready stays low during that pass, the APB port works throughout.
// A stalled output holds the update stage, and s_tready follows it back.
module key_repeat_timer_table #(
    parameter int unsigned NUM_KEYS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // key_index[7:0], down_now[8], press_edge[9], now_ms[41:10],
    // new_character[62:42], frame_start[63]
    input  logic [63:0] s_tdata,
    // operation[0]
    input  logic [0:0]  s_tuser,
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // key_fired[0], fired_character[21:1], frame_text[42:22], zeros[47:43]
    output logic [47:0] m_tdata,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import krt_pkg::*;

    localparam int unsigned AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // configuration
    logic [IVL_W-1:0] delay_reg;
    logic [IVL_W-1:0] rate_reg;
    logic             cfg_wr;

    // clearing pass
    logic [AW-1:0]    clr_cnt_reg;
    logic             clr_busy_reg;

    // stages
    sample_t          in_item;
    logic [AW-1:0]    in_addr;
    logic             in_accept;
    logic             s1_valid_reg;
    sample_t          s1_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_in_range_reg;
    logic             s1_adv;
    logic             out_valid_reg;
    result_t          out_reg;

    // memory and forwarding
    key_entry_t       mem [NUM_KEYS];
    key_entry_t       rd_data_reg;
    key_entry_t       fwd_data_reg;
    logic             fwd_hit_reg;
    key_entry_t       cur_entry;
    key_entry_t       new_entry;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    key_entry_t       mem_wdata;
    logic             item_we;

    logic [CHAR_W-1:0] text_reg;
    logic [CHAR_W-1:0] text_next;
    result_t           res_next;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since;
    logic              fire_now;
    logic [31:0]       key_wide;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_DELAY: prdata = {16'd0, delay_reg};
            REG_RATE:  prdata = {16'd0, rate_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
            rate_reg  <= RATE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_DELAY)
                delay_reg <= pwdata[IVL_W-1:0];
            else
                rate_reg <= pwdata[IVL_W-1:0];
        end
    end

    // ---------------- input ----------------
    assign in_item.operation     = s_tuser[0];
    assign in_item.key_index     = s_tdata[7:0];
    assign in_item.down_now      = s_tdata[8];
    assign in_item.press_edge    = s_tdata[9];
    assign in_item.now_ms        = s_tdata[41:10];
    assign in_item.new_character = s_tdata[62:42];
    assign in_item.frame_start   = s_tdata[63];

    assign key_wide = {24'd0, in_item.key_index};
    assign in_addr  = key_wide[AW-1:0];

    assign s1_adv    = s1_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready  = ~clr_busy_reg & (~s1_valid_reg | s1_adv);
    assign in_accept = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == AW'(NUM_KEYS - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
            fwd_hit_reg  <= item_we && (s1_addr_reg == in_addr);
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg          <= in_item;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= (key_wide < 32'(NUM_KEYS));
            fwd_data_reg    <= new_entry;
        end
    end

    // ---------------- entry memory ----------------
    assign item_we   = s1_adv & s1_in_range_reg;
    assign mem_we    = clr_busy_reg | item_we;
    assign mem_waddr = clr_busy_reg ? clr_cnt_reg : s1_addr_reg;
    assign mem_wdata = clr_busy_reg ? key_entry_t'('0) : new_entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (in_accept)
            rd_data_reg <= mem[in_addr];
    end

    // ---------------- update ----------------
    // the previous beat's write lands on the same edge as this beat's read
    assign cur_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign held      = s1_reg.now_ms - cur_entry.press_stamp;
    assign since     = s1_reg.now_ms - cur_entry.last_fire_stamp;

    always_comb
    begin
        new_entry = cur_entry;
        text_next = text_reg;
        fire_now  = 1'b0;
        res_next  = '0;
        if (s1_reg.operation == OP_SET_CHAR)
        begin
            new_entry.character = s1_reg.new_character;
        end
        else
        begin
            if (s1_reg.frame_start)
                text_next = '0;
            if (s1_in_range_reg)
            begin
                priority if (s1_reg.press_edge)
                begin
                    new_entry.press_stamp     = s1_reg.now_ms;
                    new_entry.last_fire_stamp = s1_reg.now_ms;
                    new_entry.repeating       = 1'b0;
                    res_next.key_fired        = 1'b1;
                end
                else if (s1_reg.down_now && (cur_entry.press_stamp != '0))
                begin
                    if (!cur_entry.repeating)
                    begin
                        if (held >= {16'd0, delay_reg})
                        begin
                            new_entry.repeating = 1'b1;
                            fire_now            = 1'b1;
                        end
                    end
                    else if (since >= {16'd0, rate_reg})
                    begin
                        fire_now = 1'b1;
                    end
                    if (fire_now)
                    begin
                        new_entry.last_fire_stamp = s1_reg.now_ms;
                        res_next.key_fired        = 1'b1;
                        if (cur_entry.character != '0)
                        begin
                            text_next                = cur_entry.character;
                            res_next.fired_character = cur_entry.character;
                        end
                    end
                end
                else
                begin
                    new_entry = '0;
                end
            end
        end
        res_next.frame_text = text_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                text_reg      <= text_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.frame_text, out_reg.fired_character, out_reg.key_fired};

endmodule
